// ===== design/iidl_pkg.sv =====
// ----------------------------------------------------------------------------
// iidl_pkg
// Shared sizes, codes and request/response types of the indexed list.
// ----------------------------------------------------------------------------
package iidl_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int ACTION_W = 3;
    localparam int POS_W    = 4;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    position;
        logic [WORD_W-1:0]   value;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]   read_value;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic                  ins;
        logic                  rem;
        logic [IDX_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] data;
    } cell_cmd_t;

endpackage

// ===== design/iidl_cell.sv =====
// ----------------------------------------------------------------------------
// iidl_cell
// One list slot: holds a word, loads the new word, or takes its neighbor's.
// ----------------------------------------------------------------------------
module iidl_cell (
    input  logic                           clk,
    input  logic [iidl_pkg::IDX_W-1:0]     cell_index,
    input  iidl_pkg::cell_cmd_t            cmd,
    input  logic [iidl_pkg::DATA_WIDTH-1:0] left_data,
    input  logic [iidl_pkg::DATA_WIDTH-1:0] right_data,
    output logic [iidl_pkg::DATA_WIDTH-1:0] data
);
    import iidl_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (cell_index > cmd.pos)
            begin
                data_next = left_data;
            end
            else if (cell_index == cmd.pos)
            begin
                data_next = cmd.data;
            end
        end
        else if (cmd.rem)
        begin
            if (cell_index >= cmd.pos)
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== design/indexed_insert_delete_list.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_delete_list
// Fixed-capacity ordered word list with append, insert, pop, remove, read.
// ----------------------------------------------------------------------------
// Requests arrive on req (req_valid/req_ready) carrying action, position and
// value; each request yields exactly one response on rsp (rsp_valid/rsp_ready)
// with the word read, the count after the action and a status.
// The entries live in a row of DEPTH cells. An insert or remove is applied in
// the cycle the request is taken: every cell past the position (at it, too, on
// a remove) loads from its lower or upper neighbor at once; nothing iterates.
// The response is registered: it is valid in the cycle after the request.
// One request is taken per cycle; the response register decides the pace, so
// the sustained rate is one request per cycle while responses are taken.
// When the receiver stalls, the pending response holds and req_ready drops
// until it is taken; a request and the draining response may share a cycle.
// Reset empties the list (count zero) and clears the response valid; cell
// contents are not reset and are never read before being written.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  iidl_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output iidl_pkg::rsp_t rsp
);
    import iidl_pkg::*;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;
    logic                  req_fire;
    cell_cmd_t             cmd;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [CNT_W-1:0]      pos_ext;
    logic [STATUS_W-1:0]   status;
    logic                  do_ins;
    logic                  do_rem;
    logic                  do_pop;
    logic                  do_read;
    logic [IDX_W-1:0]      ins_pos;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;
    assign pos_ext   = CNT_W'(req.position);

    // decode and status, judged against the count before the action
    always_comb
    begin
        status  = ST_OK;
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        do_pop  = 1'b0;
        do_read = 1'b0;
        ins_pos = IDX_W'(req.position);
        unique case (req.action)
            ACT_APPEND:
            begin
                ins_pos = IDX_W'(count_reg);
                if (count_reg >= CNT_W'(DEPTH))
                    status = ST_FULL;
                else
                    do_ins = 1'b1;
            end
            ACT_INSERT:
            begin
                priority if (count_reg >= CNT_W'(DEPTH))
                    status = ST_FULL;
                else if (pos_ext > count_reg)
                    status = ST_BADPOS;
                else
                    do_ins = 1'b1;
            end
            ACT_POP:
            begin
                if (count_reg == '0)
                    status = ST_EMPTY;
                else
                    do_pop = 1'b1;
            end
            ACT_REMOVE:
            begin
                priority if (count_reg == '0)
                    status = ST_EMPTY;
                else if (pos_ext >= count_reg)
                    status = ST_BADPOS;
                else
                    do_rem = 1'b1;
            end
            ACT_READ:
            begin
                priority if (count_reg == '0)
                    status = ST_EMPTY;
                else if (pos_ext >= count_reg)
                    status = ST_BADPOS;
                else
                    do_read = 1'b1;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        cmd.ins  = req_fire && do_ins;
        cmd.rem  = req_fire && do_rem;
        cmd.pos  = ins_pos;
        cmd.data = DATA_WIDTH'(req.value);
    end

    always_comb
    begin
        count_next = count_reg;
        if (req_fire)
        begin
            if (do_ins)
                count_next = count_reg + CNT_W'(1);
            else if (do_rem || do_pop)
                count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_next            = rsp_reg;
        rsp_next.read_value = do_read ? WORD_W'(cell_data[IDX_W'(req.position)]) : '0;
        rsp_next.count      = COUNT_W'(count_next);
        rsp_next.status     = status;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (req_fire)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_d;
            logic [DATA_WIDTH-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_left
                assign left_d = cell_data[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_right
                assign right_d = cell_data[gi+1];
            end
            iidl_cell u_cell (
                .clk        (clk),
                .cell_index (IDX_W'(gi)),
                .cmd        (cmd),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("list count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (count_reg == $past(count_reg))
                  || (count_reg == $past(count_reg) + CNT_W'(1))
                  || (count_reg + CNT_W'(1) == $past(count_reg)))
        else $error("count moved by more than one");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == ST_FULL |-> rsp_reg.count == COUNT_W'(DEPTH))
        else $error("full status with room left");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == ST_EMPTY |-> rsp_reg.count == '0)
        else $error("empty status with entries held");

    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.read_value != '0 |-> rsp_reg.status == ST_OK)
        else $error("read data on a failed request");

endmodule
